>>> design/openpgp_packet_header_parser_assert.svh
// Assertion macros for the packet header parser.
// Used by ophp_parse in this folder; the bodies are empty when SYNTH is defined.
`ifndef OPENPGP_PACKET_HEADER_PARSER_ASSERT_SVH
`define OPENPGP_PACKET_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH

`define OPHP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define OPHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OPHP_ASSERT(lbl, clk, rstn, prop, msg)

`define OPHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/ophp_pkg.sv
// Shared types and codes for the packet header parser.
// No dependencies; imported by every module of the block.
package ophp_pkg;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_LEN1    = 3'd1,
		PH_LEN2    = 3'd2,
		PH_LENN    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_WAIT    = 3'd5
	} phase_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOTIMPL = 2'd2;

	localparam logic [6:0] TYPE_MAX = 7'd110;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] bytes_following;
		logic        start_of_buffer;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  packet_type;
		logic [31:0] content_length;
		logic [2:0]  header_length;
		logic [32:0] total_length;
		logic        more_packets;
	} result_t;

endpackage

>>> design/ophp_in_reg.sv
// Input register stage of the packet header parser.
// Depends on ophp_pkg for the item type.
module ophp_in_reg
	import ophp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

endmodule

>>> design/ophp_parse.sv
// Header decode state machine and checks of the packet header parser.
// Depends on ophp_pkg and the assertion macro header.
`include "openpgp_packet_header_parser_assert.svh"

module ophp_parse
	import ophp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item_s1,
	output logic    res_valid,
	output result_t res
);

	phase_t      phase_q, phase_d, phase_eff;
	logic [7:0]  tag_q, tag_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  pend_q, pend_d;
	logic [2:0]  hdr_q, hdr_d;
	logic [31:0] pay_q, pay_d;

	logic [7:0]  b;
	logic [31:0] bf;
	logic [5:0]  ty;
	logic [2:0]  hdr_inc;
	logic [2:0]  pend_dec;
	logic [2:0]  pend_old;
	logic [31:0] acc_shift;
	logic [31:0] fin_len;
	logic        bad;
	logic        notimpl_type;
	logic        err_fire;
	logic        pay_fire;

	assign b         = item_s1.data_byte;
	assign bf        = item_s1.bytes_following;
	assign phase_eff = item_s1.start_of_buffer ? PH_TAG : phase_q;
	assign ty        = tag_q[6] ? tag_q[5:0] : {2'b00, tag_q[5:2]};
	assign hdr_inc   = hdr_q + 3'd1;
	assign pend_dec  = pend_q - 3'd1;
	assign acc_shift = {acc_q[23:0], b};
	assign notimpl_type = (ty == 6'd8) || (ty == 6'd9) || (ty == 6'd11)
		|| (ty == 6'd18);

	always_comb begin
		case (b[1:0])
			2'd0:    pend_old = 3'd1;
			2'd1:    pend_old = 3'd2;
			default: pend_old = 3'd4;
		endcase
	end

	always_comb begin
		case (phase_eff)
			PH_LEN1: fin_len = {24'd0, b};
			PH_LEN2: fin_len = acc_q + {24'd0, b};
			default: fin_len = acc_shift;
		endcase
	end

	assign bad = (ty == 6'd0) || ({1'b0, ty} > TYPE_MAX) || (fin_len == 32'hffff_ffff)
		|| (fin_len > bf);

	// next state
	always_comb begin
		phase_d = phase_eff;
		tag_d   = tag_q;
		acc_d   = acc_q;
		pend_d  = pend_q;
		hdr_d   = hdr_q;
		pay_d   = pay_q;
		unique case (phase_eff)
			PH_TAG: begin
				tag_d = b;
				hdr_d = 3'd1;
				acc_d = '0;
				pend_d = '0;
				pay_d = '0;
				if (!b[7]) begin
					phase_d = PH_WAIT;
				end else if (b[6]) begin
					phase_d = (bf == '0) ? PH_WAIT : PH_LEN1;
				end else if (b[1:0] == 2'd3) begin
					phase_d = PH_WAIT;
				end else begin
					pend_d  = pend_old;
					phase_d = (bf < {29'd0, pend_old}) ? PH_WAIT : PH_LENN;
				end
			end
			PH_LEN1, PH_LEN2, PH_LENN: begin
				hdr_d = hdr_inc;
				if (phase_eff == PH_LENN) begin
					acc_d  = acc_shift;
					pend_d = pend_dec;
				end
				if ((phase_eff == PH_LEN1) && (b >= 8'd192)) begin
					if (b < 8'd224) begin
						acc_d   = {19'd0, b[4:0], 8'hc0};
						phase_d = (bf == '0) ? PH_WAIT : PH_LEN2;
					end else if (b == 8'd255) begin
						acc_d   = '0;
						pend_d  = 3'd4;
						phase_d = (bf < 32'd4) ? PH_WAIT : PH_LENN;
					end else begin
						phase_d = PH_WAIT;
					end
				end else if ((phase_eff != PH_LENN) || (pend_dec == '0)) begin
					if (bad) begin
						phase_d = PH_WAIT;
					end else if (fin_len != '0) begin
						pay_d   = fin_len;
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = (bf != '0) ? PH_TAG : PH_WAIT;
					end
				end
			end
			PH_PAYLOAD: begin
				pay_d = pay_q - 32'd1;
				if (bf == '0) begin
					phase_d = PH_WAIT;
				end else if (pay_d == '0) begin
					phase_d = PH_TAG;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_eff)
			PH_TAG: begin
				if (!b[7]) begin
					res_valid = 1'b1;
					res.status = ST_INVALID;
				end else if (b[6]) begin
					res_valid  = (bf == '0);
					res.status = ST_INVALID;
				end else if (b[1:0] == 2'd3) begin
					res_valid  = 1'b1;
					res.status = ST_NOTIMPL;
				end else begin
					res_valid  = (bf < {29'd0, pend_old});
					res.status = ST_INVALID;
				end
			end
			PH_LEN1, PH_LEN2, PH_LENN: begin
				if ((phase_eff == PH_LEN1) && (b >= 8'd192)) begin
					res.status = ST_INVALID;
					if (b < 8'd224) begin
						res_valid = (bf == '0);
					end else if (b == 8'd255) begin
						res_valid = (bf < 32'd4);
					end else begin
						res_valid = 1'b1;
						if (notimpl_type) begin
							res.status = ST_NOTIMPL;
						end
					end
				end else if ((phase_eff != PH_LENN) || (pend_dec == '0)) begin
					res_valid = 1'b1;
					if (bad) begin
						res.status = ST_INVALID;
					end else begin
						res.status         = ST_OK;
						res.packet_type    = ty;
						res.content_length = fin_len;
						res.header_length  = hdr_inc;
						res.total_length   = {30'd0, hdr_inc} + {1'b0, fin_len};
						res.more_packets   = (bf != fin_len);
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= '0;
			acc_q   <= '0;
			pend_q  <= '0;
			hdr_q   <= '0;
			pay_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			acc_q   <= acc_d;
			pend_q  <= pend_d;
			hdr_q   <= hdr_d;
			pay_q   <= pay_d;
		end
	end

	assign err_fire = fire && res_valid && (res.status != ST_OK);
	assign pay_fire = fire && res_valid && (res.status == ST_OK) && (res.content_length != '0);

	`OPHP_ASSERT_NEXT(a_err_waits, clk, arst_n, err_fire, phase_q == PH_WAIT, "error not in wait")
	`OPHP_ASSERT_NEXT(a_ok_payload, clk, arst_n, pay_fire, phase_q == PH_PAYLOAD, "no payload")
	`OPHP_ASSERT_NEXT(a_pay_load, clk, arst_n, pay_fire, pay_q == $past(fin_len), "count not loaded")
	`OPHP_ASSERT(a_lenn_pending, clk, arst_n, (phase_q != PH_LENN) || (pend_q != '0), "none pending")

endmodule

>>> design/ophp_out_reg.sv
// Result register of the packet header parser.
// Depends on ophp_pkg for the result type.
module ophp_out_reg
	import ophp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

>>> design/openpgp_packet_header_parser.sv
// Packet header parser: takes one message byte per cycle and reports one result per
// packet header or error. The rate is one byte per clock, sustained for as long as the
// result side takes its transactions; a byte's result, if it has one, is loaded into the
// result register as the byte leaves the input register, and the result ports are driven
// from that register. The decode and length checks run once per byte between the
// input register and the result register. A held result stops the input register
// whenever the result register is full and stalled, whether or not the next byte has a result.
// Depends on ophp_pkg, ophp_in_reg, ophp_parse and ophp_out_reg.
module openpgp_packet_header_parser
	import ophp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [31:0] bytes_following,
	input  logic        start_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  packet_type,
	output logic [31:0] content_length,
	output logic [2:0]  header_length,
	output logic [32:0] total_length,
	output logic        more_packets
);

	item_t   item, item_s1;
	logic    valid_s1;
	logic    advance;
	logic    fire;
	logic    res_valid;
	result_t res, res_q;

	assign item.data_byte       = data_byte;
	assign item.bytes_following = bytes_following;
	assign item.start_of_buffer = start_of_buffer;

	assign advance = !out_valid || !out_stall;
	assign fire    = valid_s1 && advance;

	ophp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ophp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ophp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status         = res_q.status;
	assign packet_type    = res_q.packet_type;
	assign content_length = res_q.content_length;
	assign header_length  = res_q.header_length;
	assign total_length   = res_q.total_length;
	assign more_packets   = res_q.more_packets;

endmodule

>>> bench/openpgp_packet_header_parser_tb.sv
// Self-checking bench for openpgp_packet_header_parser: a directed table, then random
// buffers, each byte predicted in-line and each result compared field by field.
// Depends on ophp_pkg and the parser RTL only.
module openpgp_packet_header_parser_tb import ophp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TYPE_LIMIT = 110;
	localparam int STREAM_BYTES = 650;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		phase_t      phase;
		logic [7:0]  tag;
		logic [31:0] acc;
		logic [2:0]  pend;
		logic [2:0]  hseen;
		logic [31:0] remain;
	} parser_state_t;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} stream_row_t;

	typedef struct packed {
		logic        sob;
		logic [7:0]  b;
		logic [31:0] bf;
		logic        typed;
		result_t     res;
	} directed_row_t;

	typedef logic [7:0] byte_q_t[$];

	localparam result_t R_NONE = '0;
	localparam result_t R_INVALID = '{ST_INVALID, 6'd0, 32'd0, 3'd0, 33'd0, 1'b0};
	localparam result_t R_NOTIMPL = '{ST_NOTIMPL, 6'd0, 32'd0, 3'd0, 33'd0, 1'b0};
	localparam result_t R_LONGEST = '{ST_OK, 6'd63, 32'hFFFFFFFE, 3'd6, 33'h1_0000_0004, 1'b1};
	localparam result_t R_EMPTY = '{ST_OK, 6'd46, 32'd0, 3'd2, 33'd2, 1'b1};

	localparam directed_row_t DIRECTED_ROWS [27] = '{
		'{1'b1, 8'h00, 32'd0,         1'b1, R_INVALID},
		'{1'b1, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFE, 32'hFFFFFFFF,  1'b1, R_LONGEST},
		'{1'b1, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b0, R_NONE},
		'{1'b0, 8'hFF, 32'hFFFFFFFF,  1'b1, R_INVALID},
		'{1'b1, 8'hC0, 32'd10,        1'b0, R_NONE},
		'{1'b0, 8'h05, 32'd9,         1'b1, R_INVALID},
		'{1'b1, 8'hC8, 32'd5,         1'b0, R_NONE},
		'{1'b0, 8'hE0, 32'd4,         1'b1, R_NOTIMPL},
		'{1'b1, 8'hCA, 32'd5,         1'b0, R_NONE},
		'{1'b0, 8'hFE, 32'd4,         1'b1, R_INVALID},
		'{1'b1, 8'h8B, 32'd9,         1'b1, R_NOTIMPL},
		'{1'b1, 8'hC4, 32'd0,         1'b1, R_INVALID},
		'{1'b1, 8'hD0, 32'd3,         1'b0, R_NONE},
		'{1'b0, 8'hC0, 32'd2,         1'b0, R_NONE},
		'{1'b0, 8'h00, 32'd1,         1'b1, R_INVALID},
		'{1'b1, 8'hEE, 32'd2,         1'b0, R_NONE},
		'{1'b0, 8'h00, 32'd1,         1'b1, R_EMPTY},
		'{1'b0, 8'h84, 32'd0,         1'b1, R_INVALID}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic [31:0] bytes_following = 32'd0;
	logic        start_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [5:0]  packet_type;
	logic [31:0] content_length;
	logic [2:0]  header_length;
	logic [32:0] total_length;
	logic        more_packets;

	stream_row_t   byte_stream[$];
	result_t       pending_results[$];
	parser_state_t model_state;
	parser_state_t gen_state;
	int            accepted_n = 0;
	int            results_seen = 0;
	int            headers_ok = 0;
	int            live_bytes = 0;
	int            mismatches = 0;
	longint        cycles = 0;
	longint        cycle_limit = 64'd100000000;

	openpgp_packet_header_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.bytes_following(bytes_following),
		.start_of_buffer(start_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.packet_type    (packet_type),
		.content_length (content_length),
		.header_length  (header_length),
		.total_length   (total_length),
		.more_packets   (more_packets)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic parser_state_t reset_state();
		parser_state_t s;
		s.phase = PH_TAG;
		s.tag = '0;
		s.acc = '0;
		s.pend = '0;
		s.hseen = '0;
		s.remain = '0;
		return s;
	endfunction

	function automatic logic [5:0] tag_type(logic [7:0] tag);
		return tag[6] ? tag[5:0] : {2'b00, tag[5:2]};
	endfunction

	function automatic result_t header_error(inout parser_state_t s, input logic [1:0] code);
		result_t r;
		r = '0;
		r.status = code;
		s.phase = PH_WAIT;
		return r;
	endfunction

	function automatic result_t close_header(inout parser_state_t s, input logic [31:0] len,
			input logic [31:0] bf);
		result_t     r;
		logic [5:0]  ty;
		logic [31:0] rest;
		ty = tag_type(s.tag);
		if (ty == 6'd0 || int'(ty) > TYPE_LIMIT || len == 32'hFFFFFFFF || len > bf)
			return header_error(s, ST_INVALID);
		rest = bf - len;
		r.status = ST_OK;
		r.packet_type = ty;
		r.content_length = len;
		r.header_length = s.hseen;
		r.total_length = {30'd0, s.hseen} + {1'b0, len};
		r.more_packets = (rest != 0);
		if (len != 0) begin
			s.remain = len;
			s.phase = PH_PAYLOAD;
		end else if (rest != 0) begin
			s.phase = PH_TAG;
		end else begin
			s.phase = PH_WAIT;
		end
		return r;
	endfunction

	function automatic bit parse_byte(inout parser_state_t s, input item_t it,
			output result_t r, output bit ignored);
		logic [7:0]  b;
		logic [31:0] bf;
		b = it.data_byte;
		bf = it.bytes_following;
		r = '0;
		ignored = 1'b0;
		if (it.start_of_buffer)
			s.phase = PH_TAG;
		case (s.phase)
			PH_TAG: begin
				s.tag = b;
				s.hseen = 3'd1;
				s.acc = '0;
				s.pend = '0;
				s.remain = '0;
				if (!b[7]) begin
					r = header_error(s, ST_INVALID);
					return 1'b1;
				end
				if (b[6]) begin
					if (bf == 0) begin
						r = header_error(s, ST_INVALID);
						return 1'b1;
					end
					s.phase = PH_LEN1;
					return 1'b0;
				end
				if (b[1:0] == 2'd3) begin
					r = header_error(s, ST_NOTIMPL);
					return 1'b1;
				end
				s.pend = 3'd1 << b[1:0];
				if (bf < {29'd0, s.pend}) begin
					r = header_error(s, ST_INVALID);
					return 1'b1;
				end
				s.phase = PH_LENN;
				return 1'b0;
			end
			PH_LEN1: begin
				s.hseen = s.hseen + 3'd1;
				if (b < 8'd192) begin
					r = close_header(s, {24'd0, b}, bf);
					return 1'b1;
				end
				if (b < 8'd224) begin
					if (bf == 0) begin
						r = header_error(s, ST_INVALID);
						return 1'b1;
					end
					s.acc = {24'd0, b - 8'd192} * 32'd256 + 32'd192;
					s.phase = PH_LEN2;
					return 1'b0;
				end
				if (b == 8'd255) begin
					if (bf < 4) begin
						r = header_error(s, ST_INVALID);
						return 1'b1;
					end
					s.acc = '0;
					s.pend = 3'd4;
					s.phase = PH_LENN;
					return 1'b0;
				end
				case (tag_type(s.tag))
					6'd8, 6'd9, 6'd11, 6'd18: r = header_error(s, ST_NOTIMPL);
					default: r = header_error(s, ST_INVALID);
				endcase
				return 1'b1;
			end
			PH_LEN2: begin
				s.hseen = s.hseen + 3'd1;
				r = close_header(s, s.acc + {24'd0, b}, bf);
				return 1'b1;
			end
			PH_LENN: begin
				s.hseen = s.hseen + 3'd1;
				s.acc = {s.acc[23:0], b};
				s.pend = s.pend - 3'd1;
				if (s.pend == 0) begin
					r = close_header(s, s.acc, bf);
					return 1'b1;
				end
				return 1'b0;
			end
			PH_PAYLOAD: begin
				s.remain = s.remain - 32'd1;
				if (bf == 0)
					s.phase = PH_WAIT;
				else if (s.remain == 0)
					s.phase = PH_TAG;
				return 1'b0;
			end
			default: begin
				ignored = 1'b1;
				s.phase = PH_WAIT;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic push_item(logic sob, logic [7:0] b, logic [31:0] bf, bit typed = 1'b0,
			result_t res = '0);
		stream_row_t row;
		result_t     r;
		bit          ign;
		row.it.data_byte = b;
		row.it.bytes_following = bf;
		row.it.start_of_buffer = sob;
		row.typed = typed;
		row.res = res;
		byte_stream.push_back(row);
		void'(parse_byte(gen_state, row.it, r, ign));
		if (!ign)
			live_bytes++;
	endtask

	function automatic byte_q_t make_packet();
		byte_q_t    p;
		logic [5:0] ty;
		int         len;
		int         form;
		int         lt;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(0, 6);
		form = $urandom_range(0, 9);
		if ($urandom_range(0, 1)) begin
			ty = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
			p.push_back({2'b11, ty});
			if (form == 0) begin
				p.push_back(8'($urandom_range(224, 254)));
			end else if (form <= 3) begin
				p.push_back(8'hFF);
				for (int i = 3; i >= 0; i--)
					p.push_back(8'(len >> (8 * i)));
			end else if (len < 192) begin
				p.push_back(8'(len));
			end else begin
				p.push_back(8'(192 + ((len - 192) >> 8)));
				p.push_back(8'(len - 192));
			end
		end else begin
			ty = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 15));
			if (form == 0)
				lt = 3;
			else if (form <= 3)
				lt = 2;
			else if (form <= 6 || len > 255)
				lt = 1;
			else
				lt = 0;
			p.push_back({2'b10, ty[3:0], 2'(lt)});
			if (lt != 3)
				for (int i = (1 << lt) - 1; i >= 0; i--)
					p.push_back(8'(len >> (8 * i)));
		end
		for (int i = 0; i < len; i++)
			p.push_back(8'($urandom_range(0, 255)));
		return p;
	endfunction

	task automatic build_stimulus();
		byte_q_t     msg;
		logic [31:0] bfs[$];
		logic [31:0] base;
		logic [31:0] len;
		logic [31:0] bf;
		int          mode;
		int          n;
		int          k;
		logic        sob;
		gen_state = reset_state();
		foreach (DIRECTED_ROWS[i])
			push_item(DIRECTED_ROWS[i].sob, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].bf,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
		live_bytes = 0;
		while (byte_stream.size() < STREAM_BYTES) begin
			msg.delete();
			bfs.delete();
			sob = 1'b1;
			mode = $urandom_range(0, 9);
			if (mode == 6) begin
				// header only, with a large length and no payload
				len = $urandom();
				if ($urandom_range(0, 1)) begin
					msg.push_back({2'b11, 6'($urandom_range(1, 63))});
					msg.push_back(8'hFF);
				end else begin
					msg.push_back({2'b10, 4'($urandom_range(1, 15)), 2'd2});
				end
				for (int i = 3; i >= 0; i--)
					msg.push_back(len[8 * i +: 8]);
				bf = $urandom_range(0, 1) ? len + 32'($urandom_range(0, 2)) : $urandom();
				foreach (msg[i])
					bfs.push_back(bf);
			end else if (mode == 7) begin
				sob = $urandom_range(0, 1);
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					msg.push_back(8'($urandom_range(0, 255)));
					bfs.push_back($urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 4)));
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					msg = {msg, make_packet()};
				n = msg.size();
				base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hFFFFFFFF - n) : 32'd0;
				for (int i = 0; i < n; i++)
					bfs.push_back(base + 32'(n - 1 - i));
				if (mode == 8 && n > 1) begin
					k = $urandom_range(1, n - 1);
					repeat (k) begin
						void'(msg.pop_back());
						void'(bfs.pop_back());
					end
				end else if (mode == 9) begin
					k = $urandom_range(0, n - 1);
					if ($urandom_range(0, 1))
						msg[k] = 8'($urandom_range(0, 255));
					else
						bfs[k] = $urandom();
				end
			end
			foreach (msg[i])
				push_item((i == 0) ? sob : 1'b0, msg[i], bfs[i]);
		end
	endtask

	task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
		if (mismatches < 40)
			$display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t pred;
		bit      ign;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, status", {31'd0, status}, 33'd0);
				end else begin
					want = pending_results.pop_front();
					if (want.status == ST_OK)
						headers_ok++;
					if (status !== want.status)
						report_mismatch("status", {31'd0, status}, {31'd0, want.status});
					if (packet_type !== want.packet_type)
						report_mismatch("packet_type", {27'd0, packet_type},
							{27'd0, want.packet_type});
					if (content_length !== want.content_length)
						report_mismatch("content_length", {1'b0, content_length},
							{1'b0, want.content_length});
					if (header_length !== want.header_length)
						report_mismatch("header_length", {30'd0, header_length},
							{30'd0, want.header_length});
					if (total_length !== want.total_length)
						report_mismatch("total_length", total_length, want.total_length);
					if (more_packets !== want.more_packets)
						report_mismatch("more_packets", {32'd0, more_packets},
							{32'd0, want.more_packets});
				end
				results_seen++;
			end
			if (in_valid && !in_stall && accepted_n < byte_stream.size()) begin
				if (parse_byte(model_state, byte_stream[accepted_n].it, pred, ign))
					pending_results.push_back(byte_stream[accepted_n].typed ?
						byte_stream[accepted_n].res : pred);
				accepted_n++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > cycle_limit) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int gap;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int i = 0; i < byte_stream.size(); i++) begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= byte_stream[i].it.data_byte;
			bytes_following <= byte_stream[i].it.bytes_following;
			start_of_buffer <= byte_stream[i].it.start_of_buffer;
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;
	end

	initial begin
		int k;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 29) == 0)
				quiet = !quiet;
			k = quiet ? 0 : $urandom_range(0, 8);
			if (k != 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		model_state = reset_state();
		build_stimulus();
		cycle_limit = 64'(byte_stream.size()) * 100 + 2000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_n < byte_stream.size())
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run sent %0d bytes (%0d directed, %0d random bytes parsed), checked %0d results,",
			byte_stream.size(), $size(DIRECTED_ROWS), live_bytes, results_seen);
		$display("%0d good headers and %0d errors; %0d mismatches.",
			headers_ok, results_seen - headers_ok, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/ophp_pkg.sv
design/ophp_in_reg.sv
design/ophp_parse.sv
design/ophp_out_reg.sv
design/openpgp_packet_header_parser.sv
bench/openpgp_packet_header_parser_tb.sv
